FILE: hw/rtl/ale_pkg.sv
package ale_pkg;

   // List geometry and field widths
   localparam int DEPTH  = 16;
   localparam int FUNC_W = 2;
   localparam int POS_W  = 5;
   localparam int DATA_W = 32;
   localparam int CNT_W  = 5;
   localparam int STAT_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_FIND   = 2'd2,
      FUNC_CHANGE = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic                     shift_up;    // successful insert: cells above pos take left
      logic                     shift_down;  // successful delete: cells at/above pos take right
      logic                     write;       // insert or change: cell at pos loads data
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] data;
   } cell_ctrl_type;

endpackage

FILE: hw/rtl/ale_ifs.sv
// Request channel: one list operation per word
interface ale_req_if;
   logic                             valid;
   logic                             ready;
   logic [ale_pkg::FUNC_W-1:0]       func;
   logic [ale_pkg::POS_W-1:0]        position;
   logic signed [ale_pkg::DATA_W-1:0] value;

   modport source (output valid, func, position, value, input ready);
   modport sink   (input valid, func, position, value, output ready);
endinterface

// Response channel: one result word per request
interface ale_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ale_pkg::STAT_W-1:0]       status;
   logic signed [ale_pkg::DATA_W-1:0] read_value;
   logic [ale_pkg::CNT_W-1:0]        entry_count;

   modport source (output valid, status, read_value, entry_count, input ready);
   modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

FILE: hw/rtl/array_list_engine_core.sv
// A result word is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; every cell shifts or loads in parallel
// in the cycle of acceptance; only an unread output register holds it back.
// Reset: synchronous, clears the entry count and the response valid.
// The entry cells are not cleared; only indices below the count are read.
module array_list_engine_core (
   input  logic          clock,
   input  logic          reset,
   ale_req_if.sink       req_port,
   ale_rsp_if.source     rsp_port
);

   logic [ale_pkg::CNT_W-1:0]         count_ff;
   logic [ale_pkg::CNT_W-1:0]         count_in;
   logic                              rsp_valid_ff;
   ale_pkg::status_type               status_ff;
   ale_pkg::status_type               status_in;
   logic signed [ale_pkg::DATA_W-1:0] read_value_ff;
   logic signed [ale_pkg::DATA_W-1:0] read_value_in;
   logic [ale_pkg::CNT_W-1:0]         entry_count_ff;

   logic                              accept;
   ale_pkg::func_type                 func;
   logic [ale_pkg::CNT_W-1:0]         pos_ext;
   ale_pkg::cell_ctrl_type            ctrl;
   logic signed [ale_pkg::DATA_W-1:0] entry_q [ale_pkg::DEPTH];
   logic signed [ale_pkg::DATA_W-1:0] rd_q    [ale_pkg::DEPTH];
   logic signed [ale_pkg::DATA_W-1:0] rd_bus;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;
   assign func           = ale_pkg::func_type'(req_port.func);
   assign pos_ext        = ale_pkg::CNT_W'(req_port.position);

   // Decode the request against the current count
   always_comb begin
      status_in       = ale_pkg::STAT_OK;
      count_in        = count_ff;
      ctrl.shift_up   = 1'b0;
      ctrl.shift_down = 1'b0;
      ctrl.write      = 1'b0;
      ctrl.pos        = req_port.position;
      ctrl.data       = req_port.value;
      read_value_in   = '0;
      case (func)
         ale_pkg::FUNC_INSERT: begin
            if (count_ff == ale_pkg::CNT_W'(ale_pkg::DEPTH)) begin
               status_in = ale_pkg::STAT_FULL;
            end else if (pos_ext > count_ff) begin
               status_in = ale_pkg::STAT_RANGE;
            end else begin
               ctrl.shift_up = 1'b1;
               ctrl.write    = 1'b1;
               count_in      = count_ff + 1'b1;
            end
         end
         default: begin
            if (pos_ext >= count_ff) begin
               status_in = ale_pkg::STAT_RANGE;
            end else if (func == ale_pkg::FUNC_DELETE) begin
               ctrl.shift_down = 1'b1;
               count_in        = count_ff - 1'b1;
            end else if (func == ale_pkg::FUNC_FIND) begin
               read_value_in = rd_bus;
            end else begin
               ctrl.write = 1'b1;
            end
         end
      endcase
   end

   // Chain of entry cells, each wired to its neighbors; an end cell sees itself
   for (genvar i = 0; i < ale_pkg::DEPTH; i++) begin : g_cell
      logic signed [ale_pkg::DATA_W-1:0] left_d;
      logic signed [ale_pkg::DATA_W-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = entry_q[i];
      end else begin : g_mid_l
         assign left_d = entry_q[i-1];
      end
      if (i == ale_pkg::DEPTH - 1) begin : g_last
         assign right_d = entry_q[i];
      end else begin : g_mid_r
         assign right_d = entry_q[i+1];
      end
      ale_cell u_cell (
         .clock      (clock),
         .cell_index (ale_pkg::POS_W'(i)),
         .update     (accept),
         .ctrl       (ctrl),
         .left_data  (left_d),
         .right_data (right_d),
         .entry      (entry_q[i]),
         .rd_data    (rd_q[i])
      );
   end

   // Read bus: OR of the cell outputs, at most one of which is nonzero
   always_comb begin
      rd_bus = '0;
      for (int k = 0; k < ale_pkg::DEPTH; k++) begin
         rd_bus = rd_bus | rd_q[k];
      end
   end

   // Count and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         read_value_ff  <= read_value_in;
         entry_count_ff <= count_in;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = status_ff;
   assign rsp_port.read_value  = read_value_ff;
   assign rsp_port.entry_count = entry_count_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ale_pkg::CNT_W'(ale_pkg::DEPTH))
      else $error("entry count above depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && entry_count_ff == count_ff)
      else $error("response missing or count mismatch after accept");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && func == ale_pkg::FUNC_INSERT && status_in == ale_pkg::STAT_OK
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("successful insert did not grow the list");

   a_rd_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && read_value_ff != '0 |-> status_ff == ale_pkg::STAT_OK)
      else $error("nonzero read value on failed request");

endmodule

FILE: hw/rtl/ale_cell.sv
module ale_cell (
   input  logic                              clock,
   input  logic [ale_pkg::POS_W-1:0]         cell_index,
   input  logic                              update,
   input  ale_pkg::cell_ctrl_type            ctrl,
   input  logic signed [ale_pkg::DATA_W-1:0] left_data,
   input  logic signed [ale_pkg::DATA_W-1:0] right_data,
   output logic signed [ale_pkg::DATA_W-1:0] entry,
   output logic signed [ale_pkg::DATA_W-1:0] rd_data
);

   logic signed [ale_pkg::DATA_W-1:0] entry_ff;
   logic signed [ale_pkg::DATA_W-1:0] entry_in;
   logic                              hit;
   logic                              above;

   assign hit   = (cell_index == ctrl.pos);
   assign above = (cell_index > ctrl.pos);

   // Pick the neighbor or the new data for this cell
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_up && above) begin
         entry_in = left_data;
      end else if (ctrl.write && hit) begin
         entry_in = ctrl.data;
      end else if (ctrl.shift_down && (above || hit)) begin
         entry_in = right_data;
      end
   end

   // Entry payload, not reset
   always_ff @(posedge clock) begin
      if (update) begin
         entry_ff <= entry_in;
      end
   end

   assign entry   = entry_ff;
   // Only the addressed cell drives the read bus
   assign rd_data = hit ? entry_ff : '0;

endmodule

FILE: verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD  = 12;
   localparam int RESET_TICKS = 10;
   localparam int HOLD_TICKS  = 240;
   localparam int CYCLE_LIMIT = 250000;
   localparam int IDX_W       = $clog2(ale_pkg::DEPTH);

   // One list operation as the sender offers it
   typedef struct {
      ale_pkg::func_type                 func;
      logic [ale_pkg::POS_W-1:0]         position;
      logic signed [ale_pkg::DATA_W-1:0] value;
   } list_request_type;

   // One reply word as the block should return it
   typedef struct {
      ale_pkg::status_type               status;
      logic signed [ale_pkg::DATA_W-1:0] read_value;
      logic [ale_pkg::CNT_W-1:0]         entry_count;
   } list_reply_type;

   logic clock;
   logic reset;

   ale_req_if req_bus ();
   ale_rsp_if rsp_bus ();

   array_list_engine_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Shadow of the list as the block should hold it
   logic signed [ale_pkg::DATA_W-1:0] shadow_entries [ale_pkg::DEPTH];
   logic [ale_pkg::CNT_W-1:0]         shadow_count;

   list_request_type op_feed[$];
   list_reply_type   awaited_replies[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_kick      = 1'b0;
   int hold_left;
   int cycle_count    = 0;
   int fail_count     = 0;
   int ops_accepted   = 0;
   int replies_seen   = 0;
   int op_tally [4]   = '{0, 0, 0, 0};
   int full_rejects   = 0;
   int range_rejects  = 0;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Next state of the list for one operation, and the reply it yields
   function automatic list_reply_type apply_list_op(list_request_type op);
      list_reply_type r;
      r.status      = ale_pkg::STAT_OK;
      r.read_value  = '0;
      if (op.func == ale_pkg::FUNC_INSERT) begin
         if (shadow_count >= ale_pkg::DEPTH) begin
            r.status = ale_pkg::STAT_FULL;
         end else if (op.position > shadow_count) begin
            r.status = ale_pkg::STAT_RANGE;
         end else begin
            for (int i = ale_pkg::DEPTH - 1; i > 0; i--)
               if (i > op.position && i <= shadow_count)
                  shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[op.position[IDX_W-1:0]] = op.value;
            shadow_count = shadow_count + 1'b1;
         end
      end else if (op.position >= shadow_count) begin
         r.status = ale_pkg::STAT_RANGE;
      end else if (op.func == ale_pkg::FUNC_DELETE) begin
         for (int i = 0; i < ale_pkg::DEPTH - 1; i++)
            if (i >= op.position && i + 1 < shadow_count)
               shadow_entries[i] = shadow_entries[i+1];
         shadow_count = shadow_count - 1'b1;
      end else if (op.func == ale_pkg::FUNC_FIND) begin
         r.read_value = shadow_entries[op.position[IDX_W-1:0]];
      end else begin
         shadow_entries[op.position[IDX_W-1:0]] = op.value;
      end
      r.entry_count = shadow_count;
      return r;
   endfunction

   task automatic flag_mismatch(string what);
      fail_count++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // Driver: offer the next pending word unless idling
   always @(posedge clock) begin : drive_req
      list_request_type next_op;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (op_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_op          = op_feed.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.func     <= next_op.func;
            req_bus.position <= next_op.position;
            req_bus.value    <= next_op.value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_kick)
         hold_left <= HOLD_TICKS;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // Receiver: random stalls, forced low during a hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else if (hold_kick || hold_left > 1)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Monitor: check replies first, then predict for newly accepted words
   always @(posedge clock) begin : watch_ports
      list_reply_type   want;
      list_request_type seen_op;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            replies_seen++;
            if (awaited_replies.size() == 0) begin
               flag_mismatch("reply word with nothing outstanding");
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_bus.status !== want.status)
                  flag_mismatch($sformatf("status %0d, want %0d",
                                          rsp_bus.status, want.status));
               if (rsp_bus.read_value !== want.read_value)
                  flag_mismatch($sformatf("read_value %0d, want %0d",
                                          rsp_bus.read_value, want.read_value));
               if (rsp_bus.entry_count !== want.entry_count)
                  flag_mismatch($sformatf("entry_count %0d, want %0d",
                                          rsp_bus.entry_count, want.entry_count));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_op.func     = ale_pkg::func_type'(req_bus.func);
            seen_op.position = req_bus.position;
            seen_op.value    = req_bus.value;
            want = apply_list_op(seen_op);
            awaited_replies.push_back(want);
            ops_accepted++;
            op_tally[seen_op.func]++;
            if (want.status == ale_pkg::STAT_FULL)  full_rejects++;
            if (want.status == ale_pkg::STAT_RANGE) range_rejects++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles", cycle_count);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic push_op(ale_pkg::func_type f, int pos,
                          logic signed [ale_pkg::DATA_W-1:0] v);
      list_request_type op;
      op.func     = f;
      op.position = pos[ale_pkg::POS_W-1:0];
      op.value    = v;
      op_feed.push_back(op);
   endtask

   // Random words in stretches that either grow or drain the list
   task automatic queue_random_ops(int n);
      list_request_type op;
      bit growing;
      int roll;
      logic signed [ale_pkg::DATA_W-1:0] corner [4];
      corner  = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sh1};
      growing = 1'b1;
      for (int k = 0; k < n; k++) begin
         if (k % 60 == 0)
            growing = 1'($urandom_range(0, 1));
         roll = $urandom_range(0, 99);
         if (growing)
            op.func = (roll < 60) ? ale_pkg::FUNC_INSERT :
                      (roll < 75) ? ale_pkg::FUNC_DELETE :
                      (roll < 88) ? ale_pkg::FUNC_FIND : ale_pkg::FUNC_CHANGE;
         else
            op.func = (roll < 15) ? ale_pkg::FUNC_INSERT :
                      (roll < 70) ? ale_pkg::FUNC_DELETE :
                      (roll < 85) ? ale_pkg::FUNC_FIND : ale_pkg::FUNC_CHANGE;
         roll = $urandom_range(0, 99);
         if (roll < 50)
            op.position = ale_pkg::POS_W'($urandom_range(0, 3));
         else if (roll < 90)
            op.position = ale_pkg::POS_W'($urandom_range(0, ale_pkg::DEPTH));
         else
            op.position = ale_pkg::POS_W'($urandom_range(ale_pkg::DEPTH + 1, 31));
         if ($urandom_range(0, 9) == 0)
            op.value = corner[$urandom_range(0, 3)];
         else
            op.value = $urandom();
         op_feed.push_back(op);
      end
   endtask

   // Wait until the feed is used up and every reply is back
   task automatic drain_all();
      while (op_feed.size() != 0 || req_bus.valid || awaited_replies.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int n);
      @(negedge clock);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      queue_random_ops(n);
      drain_all();
   endtask

   // Stimulus sequence
   initial begin
      reset = 1'b1;
      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list misses, both ends, extremes, out-of-range
      push_op(ale_pkg::FUNC_FIND,   0,  32'sh0);
      push_op(ale_pkg::FUNC_DELETE, 0,  32'sh0);
      push_op(ale_pkg::FUNC_CHANGE, 0,  32'sh1234);
      push_op(ale_pkg::FUNC_INSERT, 1,  32'sh55);
      push_op(ale_pkg::FUNC_INSERT, 0,  32'sh7fffffff);
      push_op(ale_pkg::FUNC_INSERT, 0,  32'sh80000000);
      push_op(ale_pkg::FUNC_INSERT, 2,  -32'sh1);
      push_op(ale_pkg::FUNC_INSERT, 1,  32'sh0);
      push_op(ale_pkg::FUNC_FIND,   0,  32'sh0);
      push_op(ale_pkg::FUNC_FIND,   1,  32'sh0);
      push_op(ale_pkg::FUNC_FIND,   3,  32'sh0);
      push_op(ale_pkg::FUNC_FIND,   4,  32'sh0);
      push_op(ale_pkg::FUNC_CHANGE, 1,  32'sh2aaaaaaa);
      push_op(ale_pkg::FUNC_FIND,   1,  32'sh0);
      push_op(ale_pkg::FUNC_DELETE, 1,  32'sh0);
      push_op(ale_pkg::FUNC_DELETE, 31, 32'sh0);
      push_op(ale_pkg::FUNC_INSERT, 31, 32'sh1);
      push_op(ale_pkg::FUNC_CHANGE, 16, 32'sh1);
      push_op(ale_pkg::FUNC_DELETE, 2,  32'sh0);
      push_op(ale_pkg::FUNC_FIND,   2,  32'sh0);
      push_op(ale_pkg::FUNC_DELETE, 0,  32'sh0);
      push_op(ale_pkg::FUNC_DELETE, 0,  32'sh0);
      drain_all();

      run_phase(0,  0,  400);
      run_phase(75, 0,  350);
      run_phase(0,  75, 350);
      run_phase(6,  6,  350);

      // Long receiver hold-off while the sender keeps offering
      @(negedge clock);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_random_ops(150);
      hold_kick = 1'b1;
      @(negedge clock);
      hold_kick = 1'b0;
      drain_all();

      run_phase(0, 0, 230);

      // Let any stray reply word show up
      repeat (8) @(posedge clock);
      if (awaited_replies.size() != 0)
         flag_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));

      $display("ran %0d ops (ins %0d, del %0d, find %0d, chg %0d), %0d replies checked",
               ops_accepted, op_tally[ale_pkg::FUNC_INSERT], op_tally[ale_pkg::FUNC_DELETE],
               op_tally[ale_pkg::FUNC_FIND], op_tally[ale_pkg::FUNC_CHANGE], replies_seen);
      $display("full-list rejects %0d, range rejects %0d, mismatches %0d",
               full_rejects, range_rejects, fail_count);
      if (fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/ale_pkg.sv
hw/rtl/ale_ifs.sv
hw/rtl/ale_cell.sv
hw/rtl/array_list_engine_core.sv
verif/tb_top.sv
